// ----- src/rmap_pkg.sv -----
// Shared types and constants for the running mean accumulator with peak tracking.
package rmap_pkg;

    // Point store geometry
    localparam int POINTS = 1024;
    localparam int PT_AW  = $clog2(POINTS);
    localparam int IDX_W  = 10;

    // Datapath widths
    localparam int SUM_W   = 48;
    localparam int VAL_W   = 32;
    localparam int STEPS_W = 16;
    localparam int DEN_W   = 33;
    localparam int DIV_W   = 64;
    localparam int DCNT_W  = $clog2(DIV_W);

    localparam logic signed [VAL_W-1:0] MOST_NEG = {1'b1, {(VAL_W-1){1'b0}}};

    // Item function codes
    typedef enum logic [1:0] {
        FN_ACC   = 2'd0,
        FN_DRAIN = 2'd1,
        FN_CLEAR = 2'd2,
        FN_NOP   = 2'd3
    } t_func;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture item, read point
        logic clr_wr;  // reset sweep write
        logic mul_re;  // total * |real mean|
        logic mul_im;  // total * |imag mean|
        logic prep;    // form dividends, load dividers
        logic step;    // one quotient bit
        logic fin;     // write back, update state, load result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_done;
        logic need_div;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ----- src/rmap_if.sv -----
// Valid/ready channel interfaces for item input and result output.
interface rmap_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            func;
    logic [rmap_pkg::IDX_W-1:0]            point_index;
    logic signed [rmap_pkg::SUM_W-1:0]     re_sum;
    logic signed [rmap_pkg::SUM_W-1:0]     im_sum;
    logic [rmap_pkg::STEPS_W-1:0]          batch_steps;
    logic                                  last;

    modport source (output valid, func, point_index, re_sum, im_sum, batch_steps, last,
                    input ready);
    modport sink   (input valid, func, point_index, re_sum, im_sum, batch_steps, last,
                    output ready);
endinterface

interface rmap_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [rmap_pkg::VAL_W-1:0]     re_value;
    logic signed [rmap_pkg::VAL_W-1:0]     im_value;
    logic signed [rmap_pkg::VAL_W-1:0]     re_peak;
    logic signed [rmap_pkg::VAL_W-1:0]     im_peak;
    logic                                  peak_valid;

    modport source (output valid, re_value, im_value, re_peak, im_peak, peak_valid,
                    input ready);
    modport sink   (input valid, re_value, im_value, re_peak, im_peak, peak_valid,
                    output ready);
endinterface

// ----- src/running_mean_accumulator_with_peak_top.sv -----
// Top level of the running mean accumulator with peak tracking.
// Accumulate items go from transfer to result through a read state (S_DISP), the real and
// imaginary multiply states on the shared 32x32 multiplier (S_MULR, S_MULI), a setup state
// (S_PREP) and the bit-serial dividers (S_DIV), then write-back; with a zero divisor they go straight to write-back.
// Drain, clear and unused items go from the read state to write-back. One item is worked at a
// time: write-back waits while the result register is still held, and the next transfer is taken once back in idle.
// After reset the 1024 point store entries are zeroed in a sweep before the first transfer.
module running_mean_accumulator_with_peak_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rmap_in_if.sink     i_in,
    rmap_out_if.source  o_out
);
    rmap_pkg::t_cmd w_cmd;
    rmap_pkg::t_sts w_sts;
    logic           w_in_ready;

    assign i_in.ready = w_in_ready;

    rmap_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    rmap_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts)
    );
endmodule

// ----- src/rmap_div.sv -----
// Restoring divider, one quotient bit per step, 64-bit dividend by 33-bit divisor.
module rmap_div (
    input  logic                         i_clk,
    input  logic                         i_load,
    input  logic                         i_step,
    input  logic [rmap_pkg::DIV_W-1:0]   i_dividend,
    input  logic [rmap_pkg::DEN_W-1:0]   i_divisor,
    output logic [rmap_pkg::DIV_W-1:0]   o_quotient
);
    logic [rmap_pkg::DEN_W-1:0] r_rem;
    logic [rmap_pkg::DIV_W-1:0] r_dq;   // dividend shifts out, quotient shifts in
    logic [rmap_pkg::DEN_W:0]   w_rem_sh;
    logic [rmap_pkg::DEN_W+1:0] w_diff;
    logic                       w_ge;

    // trial subtract
    assign w_rem_sh = {r_rem, r_dq[rmap_pkg::DIV_W-1]};
    assign w_diff   = {1'b0, w_rem_sh} - {2'b00, i_divisor};
    assign w_ge     = ~w_diff[rmap_pkg::DEN_W+1];

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= '0;
            r_dq  <= i_dividend;
        end else if (i_step) begin
            r_rem <= w_ge ? w_diff[rmap_pkg::DEN_W-1:0] : w_rem_sh[rmap_pkg::DEN_W-1:0];
            r_dq  <= {r_dq[rmap_pkg::DIV_W-2:0], w_ge};
        end
    end

    assign o_quotient = r_dq;
endmodule

// ----- src/rmap_ctrl.sv -----
// Controller state machine: reset sweep, item dispatch, divide sequencing.
module rmap_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rmap_pkg::t_sts  i_sts,
    output rmap_pkg::t_cmd  o_cmd
);
    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_DISP  = 8'b0000_0100,
        S_MULR  = 8'b0000_1000,
        S_MULI  = 8'b0001_0000,
        S_PREP  = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.clr_wr = 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_state = i_sts.need_div ? S_MULR : S_FIN;
            end
            S_MULR: begin
                o_cmd.mul_re = 1'b1;
                n_state      = S_MULI;
            end
            S_MULI: begin
                o_cmd.mul_im = 1'b1;
                n_state      = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_DIV;
            end
            S_DIV: begin
                o_cmd.step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // no item taken before the sweep finishes
    a_no_load_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |-> i_sts.clr_done)
        else $error("item taken during reset sweep");

    // the last divide step hands over to finish
    a_div_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && i_sts.div_last) |=> (r_state == S_FIN))
        else $error("divide did not hand over to finish");
endmodule

// ----- src/rmap_dp.sv -----
// Datapath: point store, multiplier, dividers, peak and count state, result register.
module rmap_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    rmap_in_if.sink         i_in,
    rmap_out_if.source      o_out,
    input  rmap_pkg::t_cmd  i_cmd,
    output rmap_pkg::t_sts  o_sts
);
    localparam int VW = rmap_pkg::VAL_W;

    // point store, real and imaginary means side by side
    logic [2*VW-1:0] mem [rmap_pkg::POINTS];
    logic [2*VW-1:0] r_rd;

    // captured item; r_denom is the pending count committed on the batch's last item
    logic [1:0]                          r_func;
    logic [rmap_pkg::IDX_W-1:0]          r_idx;
    logic                                r_ok;
    logic [rmap_pkg::SUM_W-1:0]          r_re_sum, r_im_sum;
    logic                                r_last;
    logic [rmap_pkg::DEN_W-1:0]          r_denom;

    // block state
    logic [VW-1:0]                       r_total;
    logic signed [VW-1:0]                r_re_pk, r_im_pk;
    logic                                r_started;
    logic [rmap_pkg::PT_AW:0]            r_clr_cnt;

    // arithmetic
    logic [rmap_pkg::DIV_W-1:0]          r_p_re, r_p_im;
    logic                                r_neg_re, r_neg_im;
    logic [rmap_pkg::DCNT_W-1:0]         r_div_cnt;
    logic [rmap_pkg::DIV_W-1:0]          w_q_re, w_q_im;
    logic [64:0]                         w_cmb_re, w_cmb_im;

    // result register
    logic                                r_out_valid;
    logic signed [VW-1:0]                r_o_re, r_o_im, r_o_re_pk, r_o_im_pk;
    logic                                r_o_pv;

    logic signed [VW-1:0] w_re_old, w_im_old;
    logic [VW-1:0]        w_mul_op;
    logic [rmap_pkg::DIV_W-1:0] w_prod;
    logic signed [VW-1:0] w_re_new, w_im_new, w_re_pk_n, w_im_pk_n;
    logic                 w_acc;

    // magnitude of a signed mean
    function automatic logic [VW-1:0] f_abs(input logic signed [VW-1:0] v);
        return v[VW-1] ? (~v + 1'b1) : v;
    endfunction

    // signed sum of product and batch sum: {negative, magnitude}
    function automatic logic [64:0] f_combine(input logic [63:0] p, input logic oneg,
                                              input logic [rmap_pkg::SUM_W-1:0] s);
        logic                      pneg, sneg;
        logic [rmap_pkg::SUM_W-1:0] smag48;
        logic [63:0]               smag;
        pneg   = oneg && (p != '0);
        sneg   = s[rmap_pkg::SUM_W-1];
        smag48 = sneg ? (~s + 1'b1) : s;
        smag   = {16'b0, smag48};
        if (pneg == sneg) begin
            return {pneg, p + smag};
        end else if (p >= smag) begin
            return {pneg, p - smag};
        end else begin
            return {sneg, smag - p};
        end
    endfunction

    // clamp quotient into signed 32-bit range
    function automatic logic [VW-1:0] f_sat(input logic [63:0] q, input logic neg);
        if (neg) begin
            return (q > 64'h0000_0000_8000_0000) ? rmap_pkg::MOST_NEG : (~q[VW-1:0] + 1'b1);
        end else begin
            return (q > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : q[VW-1:0];
        end
    endfunction

    assign w_re_old = r_ok ? r_rd[2*VW-1:VW] : '0;
    assign w_im_old = r_ok ? r_rd[VW-1:0]    : '0;

    // shared multiplier
    assign w_mul_op = i_cmd.mul_re ? f_abs(w_re_old) : f_abs(w_im_old);
    assign w_prod   = {{VW{1'b0}}, r_total} * {{VW{1'b0}}, w_mul_op};

    assign w_cmb_re = f_combine(r_p_re, w_re_old[VW-1], r_re_sum);
    assign w_cmb_im = f_combine(r_p_im, w_im_old[VW-1], r_im_sum);

    rmap_div u_div_re (
        .i_clk      (i_clk),
        .i_load     (i_cmd.prep),
        .i_step     (i_cmd.step),
        .i_dividend (w_cmb_re[63:0]),
        .i_divisor  (r_denom),
        .o_quotient (w_q_re)
    );

    rmap_div u_div_im (
        .i_clk      (i_clk),
        .i_load     (i_cmd.prep),
        .i_step     (i_cmd.step),
        .i_dividend (w_cmb_im[63:0]),
        .i_divisor  (r_denom),
        .o_quotient (w_q_im)
    );

    // new means and running peaks
    assign w_acc    = (r_func == rmap_pkg::FN_ACC);
    assign w_re_new = (r_denom != '0) ? f_sat(w_q_re, r_neg_re) : w_re_old;
    assign w_im_new = (r_denom != '0) ? f_sat(w_q_im, r_neg_im) : w_im_old;
    assign w_re_pk_n = (!r_started || (w_re_new > r_re_pk)) ? w_re_new : r_re_pk;
    assign w_im_pk_n = (!r_started || (w_im_new > r_im_pk)) ? w_im_new : r_im_pk;

    // point store: sweep writes, write-back, registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[r_clr_cnt[rmap_pkg::PT_AW-1:0]] <= '0;
        end else if (i_cmd.fin && r_ok && (r_func != rmap_pkg::FN_NOP)) begin
            mem[r_idx[rmap_pkg::PT_AW-1:0]] <= w_acc ? {w_re_new, w_im_new} : '0;
        end
        if (i_cmd.load) begin
            r_rd <= mem[i_in.point_index[rmap_pkg::PT_AW-1:0]];
        end
    end

    // item capture and arithmetic registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func   <= i_in.func;
            r_idx    <= i_in.point_index;
            r_ok     <= (32'(i_in.point_index) < rmap_pkg::POINTS);
            r_re_sum <= i_in.re_sum;
            r_im_sum <= i_in.im_sum;
            r_last   <= i_in.last;
            r_denom  <= {1'b0, r_total} + {{(rmap_pkg::DEN_W-rmap_pkg::STEPS_W){1'b0}},
                                           i_in.batch_steps};
        end
        if (i_cmd.mul_re) begin
            r_p_re <= w_prod;
        end
        if (i_cmd.mul_im) begin
            r_p_im <= w_prod;
        end
        if (i_cmd.prep) begin
            r_neg_re <= w_cmb_re[64];
            r_neg_im <= w_cmb_im[64];
        end
    end

    // control state: sweep counter, bit counter, counts, peaks
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_div_cnt <= '0;
            r_total   <= '0;
            r_re_pk   <= rmap_pkg::MOST_NEG;
            r_im_pk   <= rmap_pkg::MOST_NEG;
            r_started <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
            if (i_cmd.prep) begin
                r_div_cnt <= '0;
            end else if (i_cmd.step) begin
                r_div_cnt <= r_div_cnt + 1'b1;
            end
            if (i_cmd.fin) begin
                case (r_func)
                    rmap_pkg::FN_ACC: begin
                        if (r_last) begin
                            r_total   <= r_denom[rmap_pkg::DEN_W-1] ? '1 : r_denom[VW-1:0];
                            r_re_pk   <= rmap_pkg::MOST_NEG;
                            r_im_pk   <= rmap_pkg::MOST_NEG;
                            r_started <= 1'b0;
                        end else begin
                            r_re_pk   <= w_re_pk_n;
                            r_im_pk   <= w_im_pk_n;
                            r_started <= 1'b1;
                        end
                    end
                    rmap_pkg::FN_CLEAR: begin
                        r_total <= '0;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.fin) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fin) begin
            r_o_re    <= '0;
            r_o_im    <= '0;
            r_o_re_pk <= '0;
            r_o_im_pk <= '0;
            r_o_pv    <= 1'b0;
            case (r_func)
                rmap_pkg::FN_ACC: begin
                    r_o_re <= w_re_new;
                    r_o_im <= w_im_new;
                    if (r_last) begin
                        r_o_re_pk <= w_re_pk_n;
                        r_o_im_pk <= w_im_pk_n;
                        r_o_pv    <= 1'b1;
                    end
                end
                rmap_pkg::FN_DRAIN: begin
                    r_o_re <= w_re_old;
                    r_o_im <= w_im_old;
                end
                default: begin
                end
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.re_value   = r_o_re;
    assign o_out.im_value   = r_o_im;
    assign o_out.re_peak    = r_o_re_pk;
    assign o_out.im_peak    = r_o_im_pk;
    assign o_out.peak_valid = r_o_pv;

    // status
    assign o_sts.clr_done = (r_clr_cnt == (rmap_pkg::PT_AW+1)'(rmap_pkg::POINTS));
    assign o_sts.need_div = w_acc && (r_denom != '0);
    assign o_sts.div_last = (r_div_cnt == '1);
    assign o_sts.out_free = !r_out_valid || o_out.ready;

    a_fin_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin |-> (!r_out_valid || o_out.ready))
        else $error("result register overwritten");

    a_step_nonzero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_denom != '0))
        else $error("divide step with zero divisor");

    a_commit_ends_batch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && w_acc && r_last) |=> (!r_started && (r_re_pk == rmap_pkg::MOST_NEG)))
        else $error("batch state not cleared on commit");
endmodule
